// ----- hdl/mse_pkg.sv -----
// Shared types and constants for the multi-stack engine.
// No dependencies; imported by multi_stack_engine.
`default_nettype none

package mse_pkg;

  // Default sizes of the stack bank.
  localparam int NUM_STACKS_DEF  = 8;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int ELEM_WIDTH_DEF  = 32;

  // Fixed widths of the port fields.
  localparam int OP_W   = 3;
  localparam int SID_W  = 3;
  localparam int DATA_W = 32;
  localparam int OFF_W  = 10;
  localparam int CNT_W  = 10;
  localparam int STAT_W = 2;

  // Capacity register value after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = 10'd1023;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_READ_TOP = 3'd2,
    OP_READ_OFF = 3'd3,
    OP_UPDATE   = 3'd4,
    OP_SIZE     = 3'd5,
    OP_CLEAR    = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_OFFSET   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/mse_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Standalone; used for the element store of multi_stack_engine.
`default_nettype none

module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // The read data holds whenever no read is issued.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/multi_stack_engine.sv -----
// Multi-stack engine: a bank of bounded LIFO stacks in one shared element RAM.
// Depends on mse_pkg and mse_ram.
//
// Usage. Operation beats arrive on the input channel (in_valid/in_ready) with
// op, stack_id, data_in and offset. Each beat yields exactly one result beat on
// the output channel (out_valid/out_ready) carrying data_out, count and status.
// Operations are push, pop, read top, read at a depth offset, update at a depth
// offset, size and clear all. A failing operation reports its status and
// leaves every count and element untouched. The capacity register must be
// written through cfg_write/cfg_data only while the block is idle; the block
// does not enforce this. The limit is the smaller of capacity and STACK_DEPTH.
//
// Timing. A result passes through the element RAM read stage and then the
// output register after its operation beat is accepted. One beat is taken
// every cycle while the output is not stalled; the single RAM port, used at
// most once per operation, sets that figure. Counts live in flip-flops and are
// updated at the accept edge, and RAM writes land at that same edge, so the
// following operation always sees the current count and element contents.
// Reset clears all counts, the capacity goes to 1023 and both pipeline stages
// empty; the element RAM is not cleared, as only pushed entries are readable.
// When the receiver stalls, the result waits in the output register, the
// operation behind it holds in the RAM read stage, and in_ready drops only once
// both are occupied.
`default_nettype none

module multi_stack_engine #(
  parameter int NUM_STACKS  = mse_pkg::NUM_STACKS_DEF,
  parameter int STACK_DEPTH = mse_pkg::STACK_DEPTH_DEF,
  parameter int ELEM_WIDTH  = mse_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [mse_pkg::CNT_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mse_pkg::OP_W-1:0]    op,
  input  wire logic [mse_pkg::SID_W-1:0]   stack_id,
  input  wire logic [mse_pkg::DATA_W-1:0]  data_in,
  input  wire logic [mse_pkg::OFF_W-1:0]   offset,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mse_pkg::DATA_W-1:0]       data_out,
  output logic [mse_pkg::CNT_W-1:0]        count,
  output logic [mse_pkg::STAT_W-1:0]       status
);

  import mse_pkg::*;

  localparam int ENTRIES = NUM_STACKS * STACK_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int EXT_W   = AW + CNT_W;
  localparam int IDX_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // Configuration and per-stack counts.
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] counts [NUM_STACKS];

  // Decode of the operation at the input.
  logic             in_fire;
  logic             sid_ok;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_next;
  logic [OFF_W-1:0] eff_off;
  logic [CNT_W-1:0] pos;
  logic [EXT_W-1:0] addr_ext;
  logic [AW-1:0]    ram_addr;
  logic             limit_hit;
  logic             ram_en;
  logic             ram_we;
  logic             use_rd;
  status_t          st;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  // RAM read stage and output handshake.
  logic             s1_valid;
  logic             s1_use_rd;
  logic [CNT_W-1:0] s1_count;
  status_t          s1_status;
  logic             advance;
  logic             counts_nonzero;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  assign sid_ok  = 32'(stack_id) < NUM_STACKS;
  assign idx     = IDX_W'(stack_id);
  assign cnt_cur = sid_ok ? counts[idx] : '0;

  // A push is refused once the count reaches capacity or the stack's slot range.
  assign limit_hit = (cnt_cur >= capacity) || (32'(cnt_cur) >= STACK_DEPTH);

  assign eff_off = (op == OP_READ_TOP || op == OP_POP) ? '0 : offset;
  assign pos     = (op == OP_PUSH) ? cnt_cur : cnt_cur - CNT_W'(1) - CNT_W'(eff_off);

  assign addr_ext  = EXT_W'(idx) * EXT_W'(STACK_DEPTH) + EXT_W'(pos);
  assign ram_addr  = addr_ext[AW-1:0];
  assign ram_wdata = ELEM_WIDTH'(data_in);

  always_comb begin
    cnt_next = cnt_cur;
    st       = ST_OK;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    use_rd   = 1'b0;
    if (sid_ok) begin
      unique case (op_t'(op))
        OP_PUSH: begin
          if (limit_hit) begin
            st = ST_OVERFLOW;
          end else begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            cnt_next = cnt_cur + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (cnt_cur == '0) begin
            st = ST_EMPTY;
          end else begin
            ram_en   = 1'b1;
            use_rd   = 1'b1;
            cnt_next = cnt_cur - CNT_W'(1);
          end
        end
        OP_READ_TOP, OP_READ_OFF, OP_UPDATE: begin
          if (cnt_cur == '0) begin
            st = ST_EMPTY;
          end else if (CNT_W'(eff_off) >= cnt_cur) begin
            st = ST_OFFSET;
          end else if (op == OP_UPDATE) begin
            ram_en = 1'b1;
            ram_we = 1'b1;
          end else begin
            ram_en = 1'b1;
            use_rd = 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_next = '0;
        end
        default: begin
        end
      endcase
    end else if (op == OP_CLEAR) begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts[i] <= '0;
      end
    end else if (in_fire) begin
      if (op == OP_CLEAR) begin
        for (int i = 0; i < NUM_STACKS; i++) begin
          counts[i] <= '0;
        end
      end else if (sid_ok) begin
        counts[idx] <= cnt_next;
      end
    end
  end

  mse_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en && in_fire),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // RAM read stage: the RAM holds its read data while this stage is stalled,
  // because no new beat is accepted then.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_use_rd <= use_rd;
      s1_count  <= cnt_next;
      s1_status <= st;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      data_out <= s1_use_rd ? DATA_W'(ram_rdata) : '0;
      count    <= s1_count;
      status   <= s1_status;
    end
  end

  always_comb begin
    counts_nonzero = 1'b0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      counts_nonzero = counts_nonzero | (counts[i] != '0);
    end
  end

  // A stalled read stage must keep its RAM data.
  a_rdata_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_use_rd && !advance |=> s1_valid && $stable(ram_rdata))
    else $error("read data changed while the read stage was stalled");

  // A successful push raises that stack's count by one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && sid_ok && op == OP_PUSH && st == ST_OK
      |=> counts[$past(idx)] == $past(cnt_cur) + CNT_W'(1))
    else $error("push did not advance the count");

  // Clear all leaves every count at zero.
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    in_fire && op == OP_CLEAR |=> !counts_nonzero)
    else $error("clear left a nonzero count");

  // A failed operation never returns element data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data_out == '0)
    else $error("error result carries data");

endmodule

`default_nettype wire
